FILE: rtl/two_button_click_classifier_macros.svh
// ----------------------------------------------------------------------------
// two_button_click_classifier_macros
// assertion macros shared by the click classifier modules
// ----------------------------------------------------------------------------
`ifndef TWO_BUTTON_CLICK_CLASSIFIER_MACROS_SVH
`define TWO_BUTTON_CLICK_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS

// concurrent check, masked while reset is held
`define TBCC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tbcc check failed");

// concurrent check that also runs during reset
`define TBCC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tbcc check failed");

`else

`define TBCC_ASSERT(label, clk, rst_n, prop)
`define TBCC_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: rtl/tbcc_pkg.sv
// ----------------------------------------------------------------------------
// tbcc_pkg
// types, codes and constants of the two-button click classifier
// ----------------------------------------------------------------------------
package tbcc_pkg;

    // field widths
    localparam int CMD_W    = 2;
    localparam int EVENT_W  = 3;
    localparam int TIMER_W  = 8;
    localparam int COUNT_W  = 2;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_POLL     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EDGE_ONE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EDGE_TWO = 2'd2;

    // click event codes
    localparam logic [EVENT_W-1:0] EV_NONE        = 3'd0;
    localparam logic [EVENT_W-1:0] EV_ONE_SINGLE  = 3'd1;
    localparam logic [EVENT_W-1:0] EV_ONE_LONG    = 3'd2;
    localparam logic [EVENT_W-1:0] EV_ONE_DOUBLE  = 3'd3;
    localparam logic [EVENT_W-1:0] EV_TWO_SINGLE  = 3'd4;
    localparam logic [EVENT_W-1:0] EV_TWO_LONG    = 3'd5;
    localparam logic [EVENT_W-1:0] EV_TWO_DOUBLE  = 3'd6;
    localparam logic [EVENT_W-1:0] EV_BOTH_SINGLE = 3'd7;

    // timer and counter constants
    localparam logic [TIMER_W-1:0] TIMER_PARKED      = 8'd255;
    localparam logic [TIMER_W-1:0] CLICK_WINDOW_RST  = 8'd50;
    localparam logic [COUNT_W-1:0] COUNT_MAX         = 2'd3;
    localparam logic [COUNT_W-1:0] COUNT_ONE         = 2'd1;
    localparam logic [COUNT_W-1:0] COUNT_TWO         = 2'd2;

    // one input beat, command in the lowest bits
    typedef struct packed {
        logic               pin_two_high;
        logic               pin_one_high;
        logic [CMD_W-1:0]   command;
    } t_item;

    // input register contents handed to the classifier
    typedef struct packed {
        logic   valid;
        t_item  item;
    } t_stage;

endpackage

FILE: rtl/tbcc_in_stage.sv
// ----------------------------------------------------------------------------
// tbcc_in_stage
// input register of the click classifier, refills in the cycle it drains
// ----------------------------------------------------------------------------
module tbcc_in_stage (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // command [1:0], pin_one_high [2], pin_two_high [3], zero fill [7:4]
    input  logic [tbcc_pkg::S_DATA_W-1:0]   i_s_tdata,
    input  logic                            i_take,
    output tbcc_pkg::t_stage                o_stage
);
    import tbcc_pkg::*;

    logic   r_valid;
    t_item  r_item;
    logic   w_load;

    // accept when empty or when the held beat moves on this cycle
    assign o_s_tready = !r_valid || i_take;
    assign w_load     = i_s_tvalid && o_s_tready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.command      <= i_s_tdata[CMD_W-1:0];
            r_item.pin_one_high <= i_s_tdata[CMD_W];
            r_item.pin_two_high <= i_s_tdata[CMD_W+1];
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

FILE: rtl/tbcc_classify.sv
// ----------------------------------------------------------------------------
// tbcc_classify
// button state, window timer and click decision with the result register
// ----------------------------------------------------------------------------
`include "two_button_click_classifier_macros.svh"

module tbcc_classify (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tbcc_pkg::t_stage                i_stage,
    input  logic [tbcc_pkg::TIMER_W-1:0]    i_click_window,
    output logic                            o_take,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // click_event [2:0], zero fill [7:3]
    output logic [tbcc_pkg::M_DATA_W-1:0]   o_m_tdata
);
    import tbcc_pkg::*;

    logic                   r_armed_one, n_armed_one;
    logic                   r_armed_two, n_armed_two;
    logic [COUNT_W-1:0]     r_presses_one, n_presses_one;
    logic [COUNT_W-1:0]     r_presses_two, n_presses_two;
    logic [TIMER_W-1:0]     r_timer, n_timer;
    logic                   r_out_valid;
    logic [EVENT_W-1:0]     r_event, n_event;
    logic [TIMER_W-1:0]     w_timer_inc;
    logic                   w_pending;
    logic                   w_not_parked;

    // the held beat moves into the result register when it is free or drains
    assign o_take = i_stage.valid && (!r_out_valid || i_m_tready);

    assign w_timer_inc  = r_timer + 1'b1;
    assign w_pending    = (r_presses_one != '0) || (r_presses_two != '0);
    assign w_not_parked = (r_timer != TIMER_PARKED);

    // next state and event for the held beat
    always_comb begin
        n_armed_one   = r_armed_one;
        n_armed_two   = r_armed_two;
        n_presses_one = r_presses_one;
        n_presses_two = r_presses_two;
        n_timer       = r_timer;
        n_event       = EV_NONE;
        unique case (i_stage.item.command)
            CMD_POLL: begin
                // re-arm released buttons once the timer runs
                if (i_stage.item.pin_one_high && w_not_parked) begin
                    n_armed_one = 1'b1;
                end
                if (i_stage.item.pin_two_high && w_not_parked) begin
                    n_armed_two = 1'b1;
                end
                if (w_pending) begin
                    n_timer = w_timer_inc;
                    if (w_timer_inc >= i_click_window) begin
                        // later rules override earlier ones
                        if (r_presses_one == COUNT_ONE) begin
                            n_event = i_stage.item.pin_one_high ? EV_ONE_SINGLE
                                                                : EV_ONE_LONG;
                        end
                        if (r_presses_one == COUNT_TWO) begin
                            n_event = EV_ONE_DOUBLE;
                        end
                        if (r_presses_two == COUNT_ONE) begin
                            n_event = i_stage.item.pin_two_high ? EV_TWO_SINGLE
                                                                : EV_TWO_LONG;
                        end
                        if (r_presses_two == COUNT_TWO) begin
                            n_event = EV_TWO_DOUBLE;
                        end
                        if (r_presses_one == COUNT_ONE && r_presses_two == COUNT_ONE) begin
                            n_event = EV_BOTH_SINGLE;
                        end
                        n_presses_one = '0;
                        n_presses_two = '0;
                        n_timer       = '0;
                    end
                end
            end
            CMD_EDGE_ONE: begin
                if (r_armed_one) begin
                    n_armed_one   = 1'b0;
                    n_timer       = TIMER_PARKED;
                    n_presses_one = (r_presses_one == COUNT_MAX) ? COUNT_MAX
                                                                 : r_presses_one + 1'b1;
                end
            end
            CMD_EDGE_TWO: begin
                if (r_armed_two) begin
                    n_armed_two   = 1'b0;
                    n_timer       = TIMER_PARKED;
                    n_presses_two = (r_presses_two == COUNT_MAX) ? COUNT_MAX
                                                                 : r_presses_two + 1'b1;
                end
            end
            default: begin
                // unused command, no state change
            end
        endcase
    end

    // button state and timer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed_one   <= 1'b1;
            r_armed_two   <= 1'b1;
            r_presses_one <= '0;
            r_presses_two <= '0;
            r_timer       <= '0;
        end else if (o_take) begin
            r_armed_one   <= n_armed_one;
            r_armed_two   <= n_armed_two;
            r_presses_one <= n_presses_one;
            r_presses_two <= n_presses_two;
            r_timer       <= n_timer;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_event <= n_event;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_DATA_W-EVENT_W){1'b0}}, r_event};

    // a running or parked timer always belongs to a pending burst
    `TBCC_ASSERT(a_timer_needs_press, i_clk, i_rst_n,
        (r_timer != '0) |-> (r_presses_one != '0 || r_presses_two != '0))
    // a reported event closes the burst
    `TBCC_ASSERT(a_event_clears, i_clk, i_rst_n,
        (o_take && n_event != EV_NONE) |=>
            (r_presses_one == '0 && r_presses_two == '0 && r_timer == '0))
    // state only moves with a beat
    `TBCC_ASSERT(a_state_holds, i_clk, i_rst_n,
        !o_take |=> ($stable(r_timer) && $stable(r_presses_one) && $stable(r_presses_two)))
    // a beat never enters a full result register that is not draining
    `TBCC_ASSERT_ALWAYS(a_no_overwrite, i_clk,
        (o_take && r_out_valid) |-> i_m_tready)

endmodule

FILE: rtl/two_button_click_classifier.sv
// ----------------------------------------------------------------------------
// two_button_click_classifier
// sorts presses on two active-low buttons into single, long and double clicks
// ----------------------------------------------------------------------------
// Takes one beat per clock unless the result side stalls: a poll tick or a
// falling edge on either button, together with both pin levels, and returns
// exactly one click_event beat for each. A beat is held in the input register
// and then moves to the result register, which offers its result; the button
// state, the press counts and the window timer are updated in the cycle the
// beat moves between the two, so back-to-back beats run at full rate while
// nothing stalls. The result side stalls on its own, and a stall there also
// holds the input side. click_window may be written only while no beat is in
// flight; it counts poll ticks after the last press.
`include "two_button_click_classifier_macros.svh"

module two_button_click_classifier (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tbcc_pkg::TIMER_W-1:0]    i_cfg_data,
    // input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // command [1:0], pin_one_high [2], pin_two_high [3], zero fill [7:4]
    input  logic [tbcc_pkg::S_DATA_W-1:0]   i_s_tdata,
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // click_event [2:0], zero fill [7:3]
    output logic [tbcc_pkg::M_DATA_W-1:0]   o_m_tdata
);
    import tbcc_pkg::*;

    logic [TIMER_W-1:0] r_click_window;
    t_stage             w_stage;
    logic               w_take;

    // click window register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_click_window <= CLICK_WINDOW_RST;
        end else if (i_cfg_valid) begin
            r_click_window <= i_cfg_data;
        end
    end

    // input register
    tbcc_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_take     (w_take),
        .o_stage    (w_stage)
    );

    // state update and result register
    tbcc_classify u_classify (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_stage        (w_stage),
        .i_click_window (r_click_window),
        .o_take         (w_take),
        .o_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .o_m_tdata      (o_m_tdata)
    );

    // the result side reports nothing before a beat arrives after reset
    `TBCC_ASSERT(a_out_after_in, i_clk, i_rst_n,
        $rose(o_m_tvalid) |-> $past(w_stage.valid))
    // pad bits of the result stay zero
    `TBCC_ASSERT(a_pad_zero, i_clk, i_rst_n,
        o_m_tvalid |-> (o_m_tdata[M_DATA_W-1:EVENT_W] == '0))
    // the input side can always take a beat when nothing is held
    `TBCC_ASSERT(a_ready_when_empty, i_clk, i_rst_n,
        !w_stage.valid |-> o_s_tready)

endmodule
